### design/rgbhsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned SAT_OUT_W   = 13;
    localparam int unsigned HUE_OUT_W   = 15;

    // degree constants
    localparam int unsigned DEG_SEXTANT = 60;
    localparam int unsigned DEG_GREEN   = 120;
    localparam int unsigned DEG_BLUE    = 240;
    localparam int unsigned DEG_FULL    = 360;

    // divider widths: remainders stay below twice the divisor
    localparam int unsigned SAT_REM_W   = CHAN_W + 1;
    localparam int unsigned SAT_DEN_W   = CHAN_W;
    localparam int unsigned HUE_REM_W   = CHAN_W + 6;
    localparam int unsigned HUE_DEN_W   = CHAN_W + 5;
    localparam int unsigned HUE_DEN_SH  = 5;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // what travels beside the two divisions
    typedef struct packed {
        logic [CHAN_W-1:0] value;
        sector_t           sector;
        logic              neg;
        logic              defined;
    } hsv_side_t;

    typedef struct packed {
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DEN_W-1:0] hue_den;
        hsv_side_t            side;
    } div_state_t;

endpackage
`default_nettype wire

### design/rgbhsv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_if
// valid/ready channels for pixel words and hsv result words
// ----------------------------------------------------------------------------
interface rgbhsv_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rgbhsv_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  value_out;
    logic [12:0] saturation_out;
    logic [14:0] hue_out;
    logic        hue_valid;

    modport source (output valid, output value_out, output saturation_out,
                    output hue_out, output hue_valid, input ready);
    modport sink   (input valid, input value_out, input saturation_out,
                    input hue_out, input hue_valid, output ready);
endinterface
`default_nettype wire

### design/rgb_to_hsv_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// pipelined 8-bit rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// Takes rgb pixel words and returns one hsv word per pixel, in order. Value
// is the largest channel; saturation is (max-min)/max in units of 2^-SAT_BITS,
// truncated; hue is in units of 2^-HUE_FRAC_BITS degree, based at 0/120/240
// degrees by the largest channel (red, then green, then blue on ties) plus
// 60*diff/delta truncated toward zero, wrapped into 0..360. Gray and black
// pixels give saturation 0, hue 0 and hue_valid low. Throughput is one pixel
// per clock while the result side does not stall, with no state kept between
// pixels. Each pixel passes the front register, a row of N = max(SAT_BITS+1,
// HUE_FRAC_BITS+6) divider cells and the back register. Each stage holds its
// word until the next one takes it, so stalls on the result side back up
// stage by stage and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit #(
    parameter int unsigned HUE_FRAC_BITS = 6,
    parameter int unsigned SAT_BITS      = 12
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rgbhsv_pix_if.sink    pixel,
    rgbhsv_res_if.source  hsv
);

    // quotient bits each division needs, and the length of the cell row
    localparam int unsigned SAT_Q_W = SAT_BITS + 1;
    localparam int unsigned HUE_Q_W = HUE_FRAC_BITS + 6;
    localparam int unsigned NCELL   = (SAT_Q_W > HUE_Q_W) ? SAT_Q_W : HUE_Q_W;

    // chain links: index k feeds cell k, index NCELL feeds the back cell
    rgbhsv_pkg::div_state_t link_state [0:NCELL];
    logic [NCELL-1:0]       link_sat_q [0:NCELL];
    logic [NCELL-1:0]       link_hue_q [0:NCELL];
    logic                   link_valid [0:NCELL];
    logic                   link_ready [0:NCELL];

    // front: min/max, sector, divider seeds
    rgbhsv_front_cell u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .red       (pixel.red_in),
        .green     (pixel.green_in),
        .blue      (pixel.blue_in),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_state (link_state[0])
    );

    // quotients start empty and fill one bit per cell
    assign link_sat_q[0] = '0;
    assign link_hue_q[0] = '0;

    // row of divider cells, one quotient bit of each division per cell
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        rgbhsv_div_cell #(
            .QW (NCELL)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_state  (link_state[k]),
            .in_sat_q  (link_sat_q[k]),
            .in_hue_q  (link_hue_q[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_state (link_state[k+1]),
            .out_sat_q (link_sat_q[k+1]),
            .out_hue_q (link_hue_q[k+1])
        );
    end

    // back: hue assembly and the result register
    rgbhsv_back_cell #(
        .QW            (NCELL),
        .SAT_Q_W       (SAT_Q_W),
        .HUE_Q_W       (HUE_Q_W),
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (link_valid[NCELL]),
        .in_ready   (link_ready[NCELL]),
        .in_state   (link_state[NCELL]),
        .in_sat_q   (link_sat_q[NCELL]),
        .in_hue_q   (link_hue_q[NCELL]),
        .out_valid  (hsv.valid),
        .out_ready  (hsv.ready),
        .value      (hsv.value_out),
        .saturation (hsv.saturation_out),
        .hue        (hsv.hue_out),
        .hue_ok     (hsv.hue_valid)
    );

endmodule
`default_nettype wire

### design/rgbhsv_front_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_front_cell
// max/min, sector pick and divider seeds for one pixel
// ----------------------------------------------------------------------------
module rgbhsv_front_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              red,
    input  wire logic [7:0]              green,
    input  wire logic [7:0]              blue,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rgbhsv_pkg::div_state_t       out_state
);

    logic                   valid_reg;
    rgbhsv_pkg::div_state_t state_reg;
    rgbhsv_pkg::div_state_t state_next;

    logic [7:0]          mx;
    logic [7:0]          mn;
    logic [7:0]          delta;
    logic signed [8:0]   diff;
    logic [7:0]          diff_mag;
    rgbhsv_pkg::sector_t sector;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        delta = mx - mn;

        // red wins ties, then green
        priority if (red == mx)
        begin
            sector = rgbhsv_pkg::SECT_RED;
            diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green == mx)
        begin
            sector = rgbhsv_pkg::SECT_GREEN;
            diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sector = rgbhsv_pkg::SECT_BLUE;
            diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        diff_mag = diff[8] ? 8'(-diff) : diff[7:0];

        state_next.sat_rem      = {1'b0, delta};
        state_next.sat_den      = mx;
        state_next.hue_rem      = 14'(diff_mag) * 14'(rgbhsv_pkg::DEG_SEXTANT);
        state_next.hue_den      = {delta, 5'd0};
        state_next.side.value   = mx;
        state_next.side.sector  = sector;
        state_next.side.neg     = diff[8];
        state_next.side.defined = (delta != 8'd0);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule
`default_nettype wire

### design/rgbhsv_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_div_cell
// one restoring step of both the saturation and the hue division
// ----------------------------------------------------------------------------
module rgbhsv_div_cell #(
    parameter int unsigned QW = 13
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire rgbhsv_pkg::div_state_t  in_state,
    input  wire logic [QW-1:0]           in_sat_q,
    input  wire logic [QW-1:0]           in_hue_q,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rgbhsv_pkg::div_state_t       out_state,
    output logic [QW-1:0]                out_sat_q,
    output logic [QW-1:0]                out_hue_q
);

    logic                   valid_reg;
    rgbhsv_pkg::div_state_t state_reg;
    rgbhsv_pkg::div_state_t state_next;
    logic [QW-1:0]          sat_q_reg;
    logic [QW-1:0]          sat_q_next;
    logic [QW-1:0]          hue_q_reg;
    logic [QW-1:0]          hue_q_next;

    logic                                 sat_ge;
    logic                                 hue_ge;
    logic [rgbhsv_pkg::SAT_REM_W-1:0]     sat_sub;
    logic [rgbhsv_pkg::HUE_REM_W-1:0]     hue_sub;
    logic [rgbhsv_pkg::SAT_REM_W-1:0]     sat_keep;
    logic [rgbhsv_pkg::HUE_REM_W-1:0]     hue_keep;

    always_comb
    begin
        sat_ge   = in_state.sat_rem >= {1'b0, in_state.sat_den};
        hue_ge   = in_state.hue_rem >= {1'b0, in_state.hue_den};
        sat_sub  = in_state.sat_rem - {1'b0, in_state.sat_den};
        hue_sub  = in_state.hue_rem - {1'b0, in_state.hue_den};
        sat_keep = sat_ge ? sat_sub : in_state.sat_rem;
        hue_keep = hue_ge ? hue_sub : in_state.hue_rem;

        // partial remainder is below the divisor, so doubling fits
        state_next         = in_state;
        state_next.sat_rem = {sat_keep[rgbhsv_pkg::SAT_REM_W-2:0], 1'b0};
        state_next.hue_rem = {hue_keep[rgbhsv_pkg::HUE_REM_W-2:0], 1'b0};
        sat_q_next         = {in_sat_q[QW-2:0], sat_ge};
        hue_q_next         = {in_hue_q[QW-2:0], hue_ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            sat_q_reg <= sat_q_next;
            hue_q_reg <= hue_q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_sat_q = sat_q_reg;
    assign out_hue_q = hue_q_reg;

endmodule
`default_nettype wire

### design/rgbhsv_back_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_back_cell
// hue assembly with wrap, field sizing and the output register
// ----------------------------------------------------------------------------
module rgbhsv_back_cell #(
    parameter int unsigned QW            = 13,
    parameter int unsigned SAT_Q_W       = 13,
    parameter int unsigned HUE_Q_W       = 12,
    parameter int unsigned HUE_FRAC_BITS = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire rgbhsv_pkg::div_state_t  in_state,
    input  wire logic [QW-1:0]           in_sat_q,
    input  wire logic [QW-1:0]           in_hue_q,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [7:0]                   value,
    output logic [12:0]                  saturation,
    output logic [14:0]                  hue,
    output logic                         hue_ok
);

    localparam int unsigned HW = HUE_FRAC_BITS + 10;
    localparam logic [HW-1:0] HUE_GREEN = HW'(rgbhsv_pkg::DEG_GREEN) << HUE_FRAC_BITS;
    localparam logic [HW-1:0] HUE_BLUE  = HW'(rgbhsv_pkg::DEG_BLUE) << HUE_FRAC_BITS;
    localparam logic [HW-1:0] HUE_FULL  = HW'(rgbhsv_pkg::DEG_FULL) << HUE_FRAC_BITS;

    logic        valid_reg;
    logic [7:0]  value_reg;
    logic [12:0] sat_reg;
    logic [12:0] sat_next;
    logic [14:0] hue_reg;
    logic [14:0] hue_next;
    logic        ok_reg;

    logic [SAT_Q_W-1:0]     sat_q;
    logic [HW-1:0]          hue_mag;
    logic [HW-1:0]          hue_base;
    logic [HW-1:0]          hue_sum;
    logic [SAT_Q_W+12:0]    sat_wide;
    logic [HW+14:0]         hue_wide;

    always_comb
    begin
        // extra low quotient bits from the longer division are dropped
        sat_q   = in_sat_q[QW-1 -: SAT_Q_W];
        hue_mag = HW'(in_hue_q[QW-1 -: HUE_Q_W]);

        unique case (in_state.side.sector)
            rgbhsv_pkg::SECT_RED:   hue_base = '0;
            rgbhsv_pkg::SECT_GREEN: hue_base = HUE_GREEN;
            rgbhsv_pkg::SECT_BLUE:  hue_base = HUE_BLUE;
            default:                hue_base = '0;
        endcase

        if (in_state.side.neg && (hue_mag != '0))
        begin
            // negative red hue wraps around the circle
            if (in_state.side.sector == rgbhsv_pkg::SECT_RED)
            begin
                hue_sum = HUE_FULL - hue_mag;
            end
            else
            begin
                hue_sum = hue_base - hue_mag;
            end
        end
        else
        begin
            hue_sum = hue_base + hue_mag;
        end

        sat_wide = {13'd0, sat_q};
        hue_wide = {15'd0, hue_sum};
        sat_next = in_state.side.defined ? sat_wide[12:0] : 13'd0;
        hue_next = in_state.side.defined ? hue_wide[14:0] : 15'd0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_reg <= in_state.side.value;
            sat_reg   <= sat_next;
            hue_reg   <= hue_next;
            ok_reg    <= in_state.side.defined;
        end
    end

    assign out_valid  = valid_reg;
    assign value      = value_reg;
    assign saturation = sat_reg;
    assign hue        = hue_reg;
    assign hue_ok     = ok_reg;

endmodule
`default_nettype wire

### design/rgbhsv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_checker
// port-level checks on the result channel of the converter
// ----------------------------------------------------------------------------
module rgbhsv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  value_out,
    input wire logic [12:0] saturation_out,
    input wire logic [14:0] hue_out,
    input wire logic        hue_valid
);

    // a stalled word stays offered
    a_valid_holds : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_word_holds : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value_out) && $stable(saturation_out)
            && $stable(hue_out) && $stable(hue_valid))
        else $error("result word changed while stalled");

    // gray or black pixels carry no hue and no saturation
    a_undefined_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hue_valid |-> hue_out == 15'd0 && saturation_out == 13'd0)
        else $error("undefined hue with nonzero hue or saturation");

    // a defined hue needs a nonzero brightest channel
    a_defined_bright : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hue_valid |-> value_out != 8'd0)
        else $error("defined hue on a black pixel");

endmodule

bind rgb_to_hsv_converter_unit rgbhsv_checker u_rgbhsv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (hsv.valid),
    .out_ready      (hsv.ready),
    .value_out      (hsv.value_out),
    .saturation_out (hsv.saturation_out),
    .hue_out        (hsv.hue_out),
    .hue_valid      (hsv.hue_valid)
);
`default_nettype wire

### verif/rgb_to_hsv_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit_tb
// self-checking bench for the pipelined rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// Pixel words go in through the valid/ready source channel. A bit-exact hsv
// predictor works out each expected result word and queues it at the moment
// the pixel is accepted. A monitor compares every accepted result word, field
// by field, with the oldest queued word. The run starts with a directed set of
// corner pixels: black, gray, pure primaries, ties between channels and hue
// wrap-around. It then sends random pixels in four back-pressure phases: no
// idling, idle sender, stalling receiver, and both.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit_tb;

    localparam int unsigned HUE_FRAC     = 6;
    localparam int unsigned SAT_FRAC     = 12;
    localparam int          HUE_UNIT     = 1 << HUE_FRAC;
    localparam int          PIPE_LATENCY = 15;
    localparam int          DRAIN_CYCLES = 4 * PIPE_LATENCY;
    localparam int          PHASE_ITEMS  = 250;
    localparam int          CYCLE_LIMIT  = 200000;

    // one expected hsv result word
    typedef struct packed {
        logic [rgbhsv_pkg::CHAN_W-1:0]    value;
        logic [rgbhsv_pkg::SAT_OUT_W-1:0] sat;
        logic [rgbhsv_pkg::HUE_OUT_W-1:0] hue;
        logic                             defined;
    } hsv_word_t;

    logic clk;
    logic rst_n;

    rgbhsv_pix_if pix_ch ();
    rgbhsv_res_if hsv_ch ();

    rgb_to_hsv_converter_unit #(
        .HUE_FRAC_BITS (HUE_FRAC),
        .SAT_BITS      (SAT_FRAC)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pix_ch),
        .hsv   (hsv_ch)
    );

    // expected hsv words, oldest first
    hsv_word_t hsv_expected_q[$];

    int src_idle_pct;
    int sink_stall_pct;
    int error_count;
    int pixels_sent;
    int words_checked;
    int undefined_hue_count;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // clock: 8 ns period
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // run limit, far beyond the slowest correct run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, hsv_expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // hsv predictor: max/min, truncated saturation, sector-based hue
    // ------------------------------------------------------------------
    function automatic hsv_word_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        hsv_word_t w;
        int ri;
        int gi;
        int bi;
        int mx;
        int mn;
        int delta;
        int base_deg;
        int diff;
        int hue;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta = mx - mn;
        w = '0;
        w.value = mx[rgbhsv_pkg::CHAN_W-1:0];
        // black and gray pixels keep sat, hue and the defined flag at zero
        if (mx != 0 && delta != 0)
        begin
            w.sat = rgbhsv_pkg::SAT_OUT_W'((delta << SAT_FRAC) / mx);
            // red wins ties, then green
            if (ri == mx)
            begin
                base_deg = 0;
                diff     = gi - bi;
            end
            else if (gi == mx)
            begin
                base_deg = int'(rgbhsv_pkg::DEG_GREEN);
                diff     = bi - ri;
            end
            else
            begin
                base_deg = int'(rgbhsv_pkg::DEG_BLUE);
                diff     = ri - gi;
            end
            // signed int division truncates toward zero
            hue = base_deg * HUE_UNIT
                + (diff * int'(rgbhsv_pkg::DEG_SEXTANT) * HUE_UNIT) / delta;
            if (hue < 0)
                hue = hue + int'(rgbhsv_pkg::DEG_FULL) * HUE_UNIT;
            w.hue     = hue[rgbhsv_pkg::HUE_OUT_W-1:0];
            w.defined = 1'b1;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // pixel sender: optional idle gap, then hold the word until accepted
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        hsv_word_t w;
        // a gap drops valid for whole cycles; without one valid stays high
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.red_in   <= r;
        pix_ch.green_in <= g;
        pix_ch.blue_in  <= b;
        @(posedge clk);
        // ready is read here before any update of this edge lands
        while (!pix_ch.ready)
            @(posedge clk);
        w = predict_hsv(r, g, b);
        if (!w.defined)
            undefined_hue_count++;
        hsv_expected_q.push_back(w);
        pixels_sent++;
    endtask

    task automatic stop_pixels();
        pix_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result receiver: random stalls per the current phase
    // ------------------------------------------------------------------
    initial
    begin
        hsv_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            hsv_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // result monitor: each accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_hsv
        hsv_word_t want;
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
        begin
            if (hsv_expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word v=%0d s=%0d h=%0d hv=%0b",
                                hsv_ch.value_out, hsv_ch.saturation_out,
                                hsv_ch.hue_out, hsv_ch.hue_valid));
            end
            else
            begin
                want = hsv_expected_q.pop_front();
                if (hsv_ch.value_out !== want.value)
                    report_mismatch($sformatf("word %0d value_out got %0d expected %0d",
                                    words_checked, hsv_ch.value_out, want.value));
                if (hsv_ch.saturation_out !== want.sat)
                    report_mismatch($sformatf("word %0d saturation_out got %0d expected %0d",
                                    words_checked, hsv_ch.saturation_out, want.sat));
                if (hsv_ch.hue_out !== want.hue)
                    report_mismatch($sformatf("word %0d hue_out got %0d expected %0d",
                                    words_checked, hsv_ch.hue_out, want.hue));
                if (hsv_ch.hue_valid !== want.defined)
                    report_mismatch($sformatf("word %0d hue_valid got %0b expected %0b",
                                    words_checked, hsv_ch.hue_valid, want.defined));
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // directed corners: black, grays, primaries, ties, hue wrap
    // ------------------------------------------------------------------
    task automatic test_corner_pixels();
        logic [23:0] corners [0:21];
        corners = '{
            24'h000000,     // black
            24'hFFFFFF,     // white, gray at the top
            24'h808080,     // mid gray
            24'h010101,     // darkest gray
            24'hFF0000,     // pure red
            24'h00FF00,     // pure green
            24'h0000FF,     // pure blue
            24'hFFFF00,     // red/green tie, red sector wins
            24'h00FFFF,     // green/blue tie, green sector wins
            24'hFF00FF,     // red/blue tie, negative hue wraps to 300
            24'hFF0001,     // red max, tiny negative hue
            24'h010000,     // smallest nonzero max
            24'hFFFEFE,     // smallest delta at full scale
            24'h010100,
            24'h000101,
            24'h0A141E,
            24'hC86432,
            24'h32C864,
            24'h6432C8,
            24'hFF0080,
            24'h010001,
            24'hFEFF00
        };
        for (int i = 0; i < 22; i++)
            send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
    endtask

    // ------------------------------------------------------------------
    // random pixels, weighted toward the awkward classes
    // ------------------------------------------------------------------
    task automatic test_random_pixels(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] top;
        logic [7:0] low;
        int         kind;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            case (kind)
                5:
                begin
                    // gray, black included now and then
                    g = r;
                    b = r;
                end
                6:
                begin
                    // two channels share the maximum
                    top = 8'($urandom_range(255, 1));
                    low = 8'($urandom_range(top - 1));
                    pick = $urandom_range(2);
                    r = (pick == 2) ? low : top;
                    g = (pick == 1) ? low : top;
                    b = (pick == 0) ? low : top;
                end
                7:
                begin
                    // near gray: small delta, hue swings hard
                    top = 8'($urandom_range(252, 3));
                    r = top + 8'($urandom_range(2)) - 8'd1;
                    g = top + 8'($urandom_range(2)) - 8'd1;
                    b = top + 8'($urandom_range(2)) - 8'd1;
                end
                8:
                begin
                    // channels at the range ends
                    if ($urandom_range(1)) r = $urandom_range(1) ? 8'hFF : 8'h00;
                    if ($urandom_range(1)) g = $urandom_range(1) ? 8'hFF : 8'h00;
                    if ($urandom_range(1)) b = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                9:
                begin
                    // two channels equal, the third one random
                    pick = $urandom_range(2);
                    if (pick == 0) b = g;
                    else if (pick == 1) r = b;
                    else g = r;
                end
                default:
                begin
                end
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        pix_ch.valid    <= 1'b0;
        pix_ch.red_in   <= '0;
        pix_ch.green_in <= '0;
        pix_ch.blue_in  <= '0;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        error_count         = 0;
        pixels_sent         = 0;
        words_checked       = 0;
        undefined_hue_count = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full rate, no gaps on either side
        test_corner_pixels();
        test_random_pixels(PHASE_ITEMS);

        // idle sender, bubbles through the pipe
        src_idle_pct = 58;
        test_random_pixels(PHASE_ITEMS);

        // stalling receiver, back-pressure stage by stage
        src_idle_pct   = 0;
        sink_stall_pct = 58;
        test_random_pixels(PHASE_ITEMS);

        // both sides irregular
        src_idle_pct   = 37;
        sink_stall_pct = 37;
        test_random_pixels(PHASE_ITEMS);

        stop_pixels();
        sink_stall_pct = 0;

        while (hsv_expected_q.size() != 0)
            @(posedge clk);
        // any stray word after the last expected one is flagged here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (hsv_expected_q.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                            hsv_expected_q.size()));

        $display("pixels sent %0d, hsv words checked %0d, gray or black %0d",
                 pixels_sent, words_checked, undefined_hue_count);
        $display("corners plus random pixels under four idle/stall mixes, %0d errors",
                 error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
design/rgbhsv_pkg.sv
design/rgbhsv_if.sv
design/rgbhsv_front_cell.sv
design/rgbhsv_div_cell.sv
design/rgbhsv_back_cell.sv
design/rgb_to_hsv_converter_unit.sv
design/rgbhsv_checker.sv
verif/rgb_to_hsv_converter_unit_tb.sv
